[rtl/mtgd_pkg.sv]
// ----------------------------------------------------------------------------
// mtgd_pkg: shared types and constants of the Gower distance core
// Field widths, variable type codes, saturation limits and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mtgd_pkg;

    // Build defaults
    localparam int MAX_VARIABLES_DEF = 256;
    localparam int FRAC_BITS_DEF     = 16;

    // Stream widths
    localparam int IN_DATA_W  = 96;   // value_a, value_b, scale
    localparam int IN_USER_W  = 5;    // a_finite, b_finite, var_type
    localparam int OUT_DATA_W = 48;   // distance, terms, zero pad
    localparam int OUT_USER_W = 1;    // is_missing

    // Field widths
    localparam int VAL_W   = 32;
    localparam int TYPE_W  = 3;
    localparam int DIST_W  = 32;
    localparam int TERMS_W = 9;

    // Arithmetic widths
    localparam int SUM_W = 48;        // running sum and term magnitude
    localparam int MAG_W = VAL_W + 2; // |a+b-2.0| of a tie column
    localparam int DVS_W = VAL_W + 1; // divisor: scale or 2*scale

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Variable type codes
    typedef enum logic [TYPE_W-1:0] {
        VT_BINARY      = 3'd0,
        VT_PRESENCE    = 3'd1,
        VT_NOMINAL     = 3'd2,
        VT_ORDINAL     = 3'd3,
        VT_MET_ORDINAL = 3'd4,
        VT_MET_INTERN  = 3'd5,
        VT_METRIC      = 3'd6,
        VT_TIE         = 3'd7
    } var_type_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input transfer
        logic prep;   // classify item, start term division if needed
        logic acc;    // add term into sum, bump count
        logic fin;    // start sum/count division
        logic emit;   // load output register, clear sum and count
    } mtgd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic last;
        logic cnt_zero;
        logic div_done;
        logic out_free;
    } mtgd_sts_t;

endpackage

[rtl/mtgd_div.sv]
// ----------------------------------------------------------------------------
// mtgd_div: shared restoring divider
// One quotient bit per cycle. The quotient
// stays in place after done until the next start.
// ----------------------------------------------------------------------------
module mtgd_div
    import mtgd_pkg::*;
#(
    parameter int DIV_W = 50
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            rem_next  = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/mtgd_dp.sv]
// ----------------------------------------------------------------------------
// mtgd_dp: Gower distance datapath
// Item register, term classification, saturating sum and term count,
// shared divider and the result output register.
// ----------------------------------------------------------------------------
module mtgd_dp
    import mtgd_pkg::*;
#(
    parameter int MAX_VARIABLES = MAX_VARIABLES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    input  mtgd_cmd_t             cmd,
    output mtgd_sts_t             sts
);

    localparam int CNT_W = $clog2(MAX_VARIABLES + 1);
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int DIV_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;

    localparam logic [SUM_W-1:0] ONE_FX  = SUM_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] TWO_FX  = MAG_W'(2) << FRAC_BITS;
    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'({1'b0, {(DIST_W-1){1'b1}}});
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'(1) << (DIST_W - 1);

    // Item register
    logic [VAL_W-1:0]  a_reg, b_reg, sc_reg;
    logic              fa_reg, fb_reg, last_reg;
    var_type_t         vt_reg;

    // Term register
    logic              use_div_reg, neg_reg, counted_reg;
    logic [SUM_W-1:0]  const_reg;

    // Running state
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register
    logic                  m_tvalid_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [TERMS_W-1:0]    terms_reg;
    logic                  miss_reg;

    // Classification
    logic [VAL_W:0]    diff;
    logic [VAL_W:0]    ratio_mag;
    logic [MAG_W-1:0]  tie_sum, tie_mag, num_mag;
    logic              tie_neg, any_pos, is_bin, is_nom, is_tie;
    logic              take, need_div, counted;
    logic [SUM_W-1:0]  const_term;

    // Divider hookup
    logic              div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quo;
    logic [DVS_W-1:0]  div_divisor;

    logic [SUM_W-1:0]  sum_mag, q_mag, div_term, term;
    logic [SUM_W:0]    sum_wide;
    logic              cnt_zero, out_free;
    logic [DIST_W-1:0] dist_val;

    // Capture input transfer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg    <= s_tdata[VAL_W-1:0];
            b_reg    <= s_tdata[2*VAL_W-1:VAL_W];
            sc_reg   <= s_tdata[3*VAL_W-1:2*VAL_W];
            fa_reg   <= s_tuser[0];
            fb_reg   <= s_tuser[1];
            vt_reg   <= var_type_t'(s_tuser[2 +: TYPE_W]);
            last_reg <= s_tlast;
        end
    end

    // |a-b| and |a+b-2.0| with sign
    assign diff      = {a_reg[VAL_W-1], a_reg} - {b_reg[VAL_W-1], b_reg};
    assign ratio_mag = diff[VAL_W] ? (~diff + 1'b1) : diff;
    assign tie_sum   = {{2{a_reg[VAL_W-1]}}, a_reg} + {{2{b_reg[VAL_W-1]}}, b_reg} - TWO_FX;
    assign tie_neg   = tie_sum[MAG_W-1];
    assign tie_mag   = tie_neg ? (~tie_sum + 1'b1) : tie_sum;

    assign is_bin  = (vt_reg == VT_BINARY) || (vt_reg == VT_PRESENCE);
    assign is_nom  = (vt_reg == VT_NOMINAL);
    assign is_tie  = (vt_reg == VT_TIE);
    assign any_pos = (!a_reg[VAL_W-1] && (a_reg != '0)) ||
                     (!b_reg[VAL_W-1] && (b_reg != '0));
    assign num_mag = is_tie ? tie_mag : MAG_W'(ratio_mag);

    // Skip non-finite pairs and binary or presence pairs with no positive value
    assign take       = fa_reg && fb_reg && (!is_bin || any_pos);
    assign need_div   = take && !is_nom && (num_mag != '0);
    assign counted    = take && !is_tie;
    assign const_term = (take && is_nom && (a_reg != b_reg)) ? ONE_FX : '0;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            use_div_reg <= need_div;
            neg_reg     <= is_tie && !tie_neg;
            counted_reg <= counted;
            const_reg   <= const_term;
        end
    end

    // Divider operands: term ratio or final sum/count
    assign sum_mag      = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign cnt_zero     = (cnt_reg == '0);
    assign div_start    = (cmd.prep && need_div) || (cmd.fin && !cnt_zero);
    assign div_dividend = cmd.fin ? DIV_W'(sum_mag) : (DIV_W'(num_mag) << FRAC_BITS);
    assign div_divisor  = cmd.fin ? DVS_W'(cnt_reg) :
                          (is_tie ? {sc_reg, 1'b0} : {1'b0, sc_reg});

    mtgd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturated, signed term
    assign q_mag    = (div_quo > DIV_W'(SUM_MAX)) ? SUM_MAX : div_quo[SUM_W-1:0];
    assign div_term = neg_reg ? (~q_mag + 1'b1) : q_mag;
    assign term     = use_div_reg ? div_term : const_reg;
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + {term[SUM_W-1], term};

    // Sum and count update
    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.emit) begin
            sum_next = '0;
            cnt_next = '0;
        end else if (cmd.acc) begin
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                sum_next = sum_wide[SUM_W-1:0];
            end
            if (counted_reg && (cnt_reg < CNT_W'(MAX_VARIABLES))) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // Final quotient, saturated to 32-bit signed
    always_comb begin
        if (sum_reg[SUM_W-1]) begin
            dist_val = (div_quo > NEG_LIM) ? NEG_LIM[DIST_W-1:0]
                                           : (~div_quo[DIST_W-1:0] + 1'b1);
        end else begin
            dist_val = (div_quo > POS_LIM) ? POS_LIM[DIST_W-1:0] : div_quo[DIST_W-1:0];
        end
    end

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            dist_reg  <= cnt_zero ? '0 : dist_val;
            terms_reg <= TERMS_W'(cnt_reg);
            miss_reg  <= cnt_zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({terms_reg, dist_reg});
    assign m_tuser  = miss_reg;

    assign sts.need_div = need_div;
    assign sts.last     = last_reg;
    assign sts.cnt_zero = cnt_zero;
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    // Checks
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (sum_reg == '0) && (cnt_reg == '0))
        else $error("sum or count not cleared after result");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_VARIABLES))
        else $error("term count above limit");

    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && miss_reg) |-> (dist_reg == '0) && (terms_reg == '0))
        else $error("missing result carries nonzero fields");

endmodule

[rtl/mtgd_ctrl.sv]
// ----------------------------------------------------------------------------
// mtgd_ctrl: Gower distance controller
// Sequences one item at a time: capture, classify, divide if needed,
// accumulate, and on the last item the final division and result hand-off.
// ----------------------------------------------------------------------------
module mtgd_ctrl
    import mtgd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  mtgd_sts_t sts,
    output mtgd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ACC,
        ST_FIN,
        ST_FDIV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   tready_reg, tready_next;
    logic   load;

    assign load = s_tvalid && tready_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = sts.need_div ? ST_DIV : ST_ACC;
            end
            ST_DIV: begin
                if (sts.div_done) state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                state_next = sts.cnt_zero ? ST_EMIT : ST_FDIV;
            end
            ST_FDIV: begin
                if (sts.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        tready_next = (state_next == ST_IDLE);
    end

    // State and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            tready_reg <= tready_next;
        end
    end

    // Datapath commands
    assign cmd.load = load;
    assign cmd.prep = (state_reg == ST_PREP);
    assign cmd.acc  = (state_reg == ST_ACC);
    assign cmd.fin  = (state_reg == ST_FIN);
    assign cmd.emit = (state_reg == ST_EMIT) && sts.out_free;

    assign s_tready = tready_reg;

endmodule

[rtl/mixed_type_gower_distance_core.sv]
// An item that needs a ratio waits on the shared one-bit-per-cycle divider;
// other items skip it. A last item adds the sum/count division, unless no
// term was counted, before the result is offered.
// Throughput: one item at a time; s_tready is high only between items.
// Reset (aresetn low, synchronous) clears sum, count, state and the output valid.
// ----------------------------------------------------------------------------
// mixed_type_gower_distance_core: Gower distance with ordinal tie correction
// Accumulates per-variable contributions of an observation pair and emits
// the saturated mean on the item flagged by s_tlast.
// ----------------------------------------------------------------------------
module mixed_type_gower_distance_core
    import mtgd_pkg::*;
#(
    parameter int MAX_VARIABLES = MAX_VARIABLES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value_a, value_b, scale
    input  logic [IN_USER_W-1:0]  s_tuser,   // a_finite, b_finite, var_type
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // distance, terms, zero pad
    output logic [OUT_USER_W-1:0] m_tuser    // is_missing
);

    mtgd_cmd_t cmd;
    mtgd_sts_t sts;

    mtgd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtgd_dp #(
        .MAX_VARIABLES (MAX_VARIABLES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

[tb/mixed_type_gower_distance_core_tb.sv]
// ----------------------------------------------------------------------------
// mixed_type_gower_distance_core_tb: self-checking bench for the Gower core
// Streams variable items of observation pairs into the core, folds each
// accepted transfer into a local Gower predictor and compares every result
// transfer against the oldest predicted distance. Covers directed extremes,
// term-count saturation, a long output stall and three randomized phases.
// ----------------------------------------------------------------------------
module mixed_type_gower_distance_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtgd_pkg::*;

    localparam int     FRAC           = FRAC_BITS_DEF;
    localparam int     MAX_VARS       = MAX_VARIABLES_DEF;
    localparam longint TERM_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint TERM_MIN       = -TERM_MAX - 1;
    localparam longint ONE_Q          = 64'sd1 <<< FRAC;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 200;
    localparam int     RX_HOLD_CYCLES = 600;

    // One variable of an observation pair
    typedef struct {
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic                    a_finite;
        logic                    b_finite;
        var_type_t               vtype;
        logic [VAL_W-1:0]        scale;
        logic                    last;
    } gower_item_t;

    // One distance result
    typedef struct {
        logic signed [DIST_W-1:0] distance;
        logic                     is_missing;
        logic [TERMS_W-1:0]       terms;
    } gower_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // value_a, value_b, scale
    logic [IN_USER_W-1:0]  s_tuser  = '0;   // a_finite, b_finite, var_type
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // distance, terms, zero pad
    logic [OUT_USER_W-1:0] m_tuser;         // is_missing

    // Predictor state of the pair being folded
    longint        pair_sum   = 0;
    int unsigned   pair_terms = 0;
    gower_result_t pending_distances[$];

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_reqs   = 0;
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    mixed_type_gower_distance_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // (num << FRAC) / den, truncated toward zero, magnitude capped at the 48-bit signed maximum
    function automatic longint scaled_quotient(input longint num,
                                               input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? -num : num;
        if (den == 0) q = (mag != 0) ? TERM_MAX : 0;
        else q = (mag << FRAC) / den;
        if (q > TERM_MAX) q = TERM_MAX;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void add_to_pair(input longint term, input bit counted);
        longint s;
        s = pair_sum + term;
        if (s > TERM_MAX) s = TERM_MAX;
        else if (s < TERM_MIN) s = TERM_MIN;
        pair_sum = s;
        if (counted && pair_terms < MAX_VARS) pair_terms++;
    endfunction

    // Fold one accepted variable; on the last one queue the expected mean
    function automatic void fold_variable(input gower_item_t it);
        longint          a;
        longint          b;
        longint          ad;
        longint unsigned mag;
        longint unsigned q;
        longint          neg_q;
        gower_result_t   r;
        a  = it.value_a;
        b  = it.value_b;
        ad = (a > b) ? a - b : b - a;
        if (it.a_finite && it.b_finite) begin
            case (it.vtype)
                VT_BINARY, VT_PRESENCE: begin
                    if (a > 0 || b > 0) add_to_pair(scaled_quotient(ad, it.scale), 1'b1);
                end
                VT_NOMINAL: add_to_pair((a == b) ? 0 : ONE_Q, 1'b1);
                VT_TIE: begin
                    add_to_pair(-scaled_quotient(a + b - 2 * ONE_Q,
                                                 longint'(it.scale) << 1), 1'b0);
                end
                default: add_to_pair(scaled_quotient(ad, it.scale), 1'b1);
            endcase
        end
        if (!it.last) return;
        if (pair_terms == 0) begin
            r.distance   = '0;
            r.is_missing = 1'b1;
            r.terms      = '0;
        end else begin
            mag = (pair_sum < 0) ? -pair_sum : pair_sum;
            q   = mag / pair_terms;
            if (pair_sum < 0) begin
                neg_q      = -longint'(q);
                r.distance = (q > 64'h8000_0000) ? 32'sh8000_0000 : neg_q[DIST_W-1:0];
            end else begin
                r.distance = (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[DIST_W-1:0];
            end
            r.is_missing = 1'b0;
            r.terms      = pair_terms[TERMS_W-1:0];
        end
        pending_distances.push_back(r);
        pair_sum   = 0;
        pair_terms = 0;
    endfunction

    function automatic gower_item_t make_item(input logic signed [VAL_W-1:0] a,
                                              input logic signed [VAL_W-1:0] b,
                                              input logic fa, input logic fb,
                                              input var_type_t vt,
                                              input logic [VAL_W-1:0] sc,
                                              input logic last);
        gower_item_t it;
        it.value_a  = a;
        it.value_b  = b;
        it.a_finite = fa;
        it.b_finite = fb;
        it.vtype    = vt;
        it.scale    = sc;
        it.last     = last;
        return it;
    endfunction

    // Mix of rail values, full-range words and small values around zero
    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] random_scale();
        logic [VAL_W-1:0] sc;
        case ($urandom_range(7))
            0:       sc = 32'hFFFF_FFFF;
            1:       sc = 32'h1;
            2, 3:    sc = $urandom;
            default: sc = $urandom_range(32'h0002_0000, 1);
        endcase
        return (sc == 0) ? 32'h1 : sc;
    endfunction

    function automatic gower_item_t random_item(input logic last);
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        a = random_value();
        b = ($urandom_range(3) == 0) ? a : random_value();
        return make_item(a, b, $urandom_range(19) != 0, $urandom_range(19) != 0,
                         var_type_t'($urandom_range(7)), random_scale(), last);
    endfunction

    // Offer one item after a random gap; valid stays high for back-to-back items
    task automatic send_item(input gower_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.scale, it.value_b, it.value_a};
        s_tuser  <= {it.vtype, it.b_finite, it.a_finite};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        fold_variable(it);
    endtask

    // Called in the step of the final transfer so no stale item is offered
    task automatic stop_offering();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // widest difference over the smallest scale: mean saturates high
        send_item(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1, VT_METRIC, 32'h1, 1));
        // nominal match, then mismatch
        send_item(make_item(32'sh0001_8000, 32'sh0001_8000, 1, 1, VT_NOMINAL,
                            32'h0001_0000, 1));
        send_item(make_item(32'sh0001_8000, 32'sh0001_8001, 1, 1, VT_NOMINAL,
                            32'h0001_0000, 1));
        // binary/presence with no positive value count nothing: missing result
        send_item(make_item(0, -5, 1, 1, VT_BINARY, 32'h0001_0000, 0));
        send_item(make_item(32'sh8000_0000, 0, 1, 1, VT_PRESENCE, 32'h0001_0000, 1));
        // every ratio type in one pair
        send_item(make_item(32'sh0001_0000, 0, 1, 1, VT_BINARY, 32'h0004_0000, 0));
        send_item(make_item(0, 32'sh0003_0000, 1, 1, VT_PRESENCE, 32'h0004_0000, 0));
        send_item(make_item(32'sh0002_8000, -32'sh8000, 1, 1, VT_ORDINAL,
                            32'h0003_0000, 0));
        send_item(make_item(-32'sh0005_0000, 32'sh0001_0000, 1, 1, VT_MET_ORDINAL,
                            32'h0007_0000, 0));
        send_item(make_item(32'sh1234_5678, -32'sh0765_4321, 1, 1, VT_MET_INTERN,
                            32'h0ABC_DEF1, 0));
        send_item(make_item(-32'sh0000_0001, 32'sh0000_0002, 1, 1, VT_METRIC,
                            32'h0000_0003, 1));
        // non-finite on either side or both: skipped, pair ends missing
        send_item(make_item(32'sh0001_0000, 0, 0, 1, VT_METRIC, 32'h0001_0000, 0));
        send_item(make_item(0, 32'sh0001_0000, 1, 0, VT_NOMINAL, 32'h0001_0000, 0));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, VT_TIE, 32'h1, 1));
        // tie terms: positive below 2.0, zero at exactly 2.0, not counted
        send_item(make_item(0, 0, 1, 1, VT_TIE, 32'h0001_0000, 0));
        send_item(make_item(32'sh0001_0000, 32'sh0001_0000, 1, 1, VT_TIE, 32'h1, 0));
        send_item(make_item(5, 5, 1, 1, VT_NOMINAL, 32'h0001_0000, 1));
        // saturated tie drags the mean to the negative rail
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, VT_TIE, 32'h1, 0));
        send_item(make_item(7, 7, 1, 1, VT_NOMINAL, 32'h1, 1));
        // running sum clamps high, a saturated tie then lands it at zero
        send_item(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1, VT_METRIC, 32'h1, 0));
        send_item(make_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 1, VT_METRIC, 32'h1, 0));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, VT_TIE, 32'h1, 1));
        // running sum clamps low, a saturated ratio then lands it at -1 LSB
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, VT_TIE, 32'h1, 0));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, VT_TIE, 32'h1, 0));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1, VT_ORDINAL, 32'h1, 1));
        stop_offering();
    endtask

    // More counted variables than the count can hold; widest scale on the tie
    task automatic test_term_count_limit();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1, VT_TIE,
                            32'hFFFF_FFFF, 0));
        send_item(make_item(1, 0, 1, 1, VT_METRIC, 32'hFFFF_FFFF, 0));
        for (int i = 0; i < 300; i++) begin
            send_item(make_item(i, i + 1, 1, 1, VT_NOMINAL, 32'h0001_0000, i == 299));
        end
        stop_offering();
    endtask

    // Receiver stalls for a long stretch while short pairs keep coming
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_reqs++;
        for (int i = 0; i < 30; i++) begin
            send_item(random_item(1'b1));
        end
        stop_offering();
    endtask

    // Random pairs, mostly short, some long; a few variables are non-finite
    task automatic test_random_pairs(input int tx_pct, input int rx_pct,
                                     input int n_items);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent        = 0;
        while (sent < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                send_item(random_item(i == len - 1));
            end
            sent += len;
        end
        stop_offering();
    endtask

    // Result receiver: random ready, or a counted hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result transfer with the oldest predicted distance
    always @(posedge aclk) begin
        gower_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_distances.size() == 0) begin
                $error("result with none pending: distance %0d, terms %0d, is_missing %0b",
                       $signed(m_tdata[DIST_W-1:0]), m_tdata[DIST_W +: TERMS_W],
                       m_tuser[0]);
                mismatch_count++;
            end else begin
                want = pending_distances.pop_front();
                if (m_tdata[DIST_W-1:0] !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance,
                           $signed(m_tdata[DIST_W-1:0]));
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.is_missing) begin
                    $error("is_missing: expected %0b, got %0b", want.is_missing,
                           m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tdata[DIST_W +: TERMS_W] !== want.terms) begin
                    $error("terms: expected %0d, got %0d", want.terms,
                           m_tdata[DIST_W +: TERMS_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_term_count_limit();
        test_output_backpressure();
        test_random_pairs(10, 69, 180);
        test_random_pairs(69, 10, 180);
        test_random_pairs(0, 0, 180);
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[mixed_type_gower_distance_core.f]
rtl/mtgd_pkg.sv
rtl/mtgd_div.sv
rtl/mtgd_dp.sv
rtl/mtgd_ctrl.sv
rtl/mixed_type_gower_distance_core.sv
tb/mixed_type_gower_distance_core_tb.sv
